@@ design/gb5_pkg.sv @@
// ============================================================================
// gb5_pkg: shared definitions for the 5x5 Gaussian blur
// Register indexes, field widths, defaults and the control word that travels
// with each item down the blur pipeline.
// ============================================================================
`default_nettype none

package gb5_pkg;

    // Default and limits of the configuration
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MIN_DIM       = 5;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    // Field widths
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int IMG_W_BITS  = 12;
    localparam int IMG_H_BITS  = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int LINES       = 4;

    // Sum widths: one weighted row sum is at most 10*255, the full sum 100*255
    localparam int HSUM_W = 12;
    localparam int VSUM_W = 15;

    // Division by the kernel sum 100: (sum * 5243) >> 19 is exact for sum < 2^15
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int PROD_W = VSUM_W + RECIP_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } gb5_reg_e;

    // Control word of one item in flight
    typedef struct packed {
        logic emit;      // the item releases one result
        logic interior;  // the result is blurred, else the center is copied
        logic last;      // final result of the frame
    } gb5_ctl_t;

    typedef logic [PIX_W-1:0] gb5_pix_t;

endpackage

`default_nettype wire

@@ design/gb5_stream_if.sv @@
// ============================================================================
// gb5 stream interfaces
// Valid/ready channels for incoming pixels and outgoing blurred pixels.
// ============================================================================
`default_nettype none

interface gb5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       flush_item;

    modport source (output valid, blue_in, green_in, red_in, flush_item, input ready);
    modport sink   (input valid, blue_in, green_in, red_in, flush_item, output ready);
endinterface

interface gb5_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_last;

    modport source (output valid, blue_out, green_out, red_out, frame_last, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, frame_last, output ready);
endinterface

`default_nettype wire

@@ design/gaussian_blur_5x5.sv @@
// ============================================================================
// gaussian_blur_5x5: streaming 5x5 weighted blur of a BGR raster
// Four line buffers and a 5x5 window feed a short pipeline that blurs each
// channel with weights (1,2,4,2,1) x (1,2,4,2,1) and divides by 100.
// ============================================================================
// Usage:
//   pix_in carries one pixel (or a flush item) per item in raster order;
//   pix_out carries blurred pixels, border pixels copied unchanged, with
//   frame_last set on the final pixel of a frame. After the last pixel of a
//   frame the host sends flush items until frame_last has appeared.
//   The result for a frame position is released by the item 2*width+2
//   positions later in the stream.
//   Throughput is one item per clock while pix_out does not stall. An
//   accepted item passes the line buffer read, the window, the row sums,
//   the column sum and the divide, and its result is held in the output register.
//   The line buffer is one memory of MAX_WIDTH words of four pixels, read
//   at acceptance and written back one stage later.
//   cfg_we writes image_width (index 0) or image_height (index 1) and restarts
//   the frame; the user must write only while the block is idle (not enforced).
//   Reset clears the window, all positions and the pipeline, and loads a
//   width of 640 and a height of 480. The line buffer is not cleared.
//   When pix_out stalls, the stages fill one by one; pix_in drops ready
//   only once every stage holds an item.
// ============================================================================
`default_nettype none

module gaussian_blur_5x5 #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gb5_in_if.sink                              pix_in,
    gb5_out_if.source                           pix_out,
    input  wire logic                           cfg_we,
    input  wire logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data
);

    import gb5_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = CW + 1;
    localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int MEM_W   = LINES * PIX_W;

    // Weighted sum of five taps with weights 1,2,4,2,1.
    function automatic logic [VSUM_W-1:0] tap_sum(
        input logic [VSUM_W-1:0] a,
        input logic [VSUM_W-1:0] b,
        input logic [VSUM_W-1:0] c,
        input logic [VSUM_W-1:0] d,
        input logic [VSUM_W-1:0] e
    );
        tap_sum = a + (b << 1) + (c << 2) + (d << 1) + e;
    endfunction

    // ------------------------------------------------------------------
    // Configuration and position registers
    // ------------------------------------------------------------------
    logic [WW-1:0]         w_eff_reg;
    logic [IMG_H_BITS-1:0] h_eff_reg;
    logic [CW-1:0]         in_column_reg, in_column_next;
    logic [1:0]            in_row_reg, in_row_next;
    logic [CW-1:0]         out_column_reg, out_column_next;
    logic [IMG_H_BITS-1:0] out_row_reg, out_row_next;

    logic [WW-1:0]         w_cfg;
    logic [IMG_H_BITS-1:0] h_cfg;
    logic [IMG_W_BITS-1:0] w_raw;

    // Pipeline control
    logic      in_acc;
    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic      s1_adv, s2_rdy, s2_adv, s3_rdy, s3_adv, s4_rdy, s4_adv, out_rdy;
    gb5_ctl_t  acc_ctl;
    gb5_ctl_t  s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;

    // Clamp the written width and height to the supported range.
    always_comb
    begin
        w_raw = cfg_data[IMG_W_BITS-1:0];
        if (32'(w_raw) < 32'(MIN_DIM))
            w_cfg = WW'(MIN_DIM);
        else if (32'(w_raw) > 32'(MAX_WIDTH))
            w_cfg = WW'(MAX_WIDTH);
        else
            w_cfg = WW'(w_raw);
        if (32'(cfg_data[IMG_H_BITS-1:0]) < 32'(MIN_DIM))
            h_cfg = IMG_H_BITS'(MIN_DIM);
        else
            h_cfg = cfg_data[IMG_H_BITS-1:0];
    end

    // Decide what the accepted item releases and advance the positions.
    always_comb
    begin
        logic [WW-1:0]         in_col_inc;
        logic [WW-1:0]         out_col_inc;
        logic [IMG_H_BITS:0]   out_row_ext;
        in_col_inc  = {1'b0, in_column_reg} + WW'(1);
        out_col_inc = {1'b0, out_column_reg} + WW'(1);
        out_row_ext = {1'b0, out_row_reg};

        acc_ctl.emit = (in_row_reg == 2'd3) ||
                       ((in_row_reg == 2'd2) && (in_column_reg >= CW'(2)));
        acc_ctl.interior = (out_row_reg >= IMG_H_BITS'(2)) &&
                           ((out_row_ext + (IMG_H_BITS+1)'(2)) < {1'b0, h_eff_reg}) &&
                           (out_column_reg >= CW'(2)) &&
                           ((out_col_inc + WW'(1)) < w_eff_reg);
        acc_ctl.last = ((out_row_ext + (IMG_H_BITS+1)'(1)) == {1'b0, h_eff_reg}) &&
                       (out_col_inc == w_eff_reg);

        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;

        if (acc_ctl.emit && acc_ctl.last)
        begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
        end
        else
        begin
            if (acc_ctl.emit)
            begin
                if (out_col_inc >= w_eff_reg)
                begin
                    out_column_next = '0;
                    out_row_next    = out_row_reg + IMG_H_BITS'(1);
                end
                else
                begin
                    out_column_next = out_col_inc[CW-1:0];
                end
            end
            if (in_col_inc >= w_eff_reg)
            begin
                in_column_next = '0;
                if (in_row_reg != 2'd3)
                    in_row_next = in_row_reg + 2'd1;
            end
            else
            begin
                in_column_next = in_col_inc[CW-1:0];
            end
        end
    end

    // Configuration writes restart the frame; accepted items move it on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg      <= WW'(W_RESET);
            h_eff_reg      <= IMG_H_BITS'(HEIGHT_RESET);
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (gb5_reg_e'(cfg_index))
                REG_IMAGE_WIDTH:  w_eff_reg <= w_cfg;
                REG_IMAGE_HEIGHT: h_eff_reg <= h_cfg;
                default:          w_eff_reg <= w_eff_reg;
            endcase
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else if (in_acc)
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake chain: each stage moves when the one after it has room.
    // ------------------------------------------------------------------
    assign out_rdy = !out_valid_reg || pix_out.ready;
    assign s4_adv  = s4_valid_reg && out_rdy;
    assign s4_rdy  = !s4_valid_reg || out_rdy;
    assign s3_adv  = s3_valid_reg && s4_rdy;
    assign s3_rdy  = !s3_valid_reg || s4_rdy;
    assign s2_adv  = s2_valid_reg && s3_rdy;
    assign s2_rdy  = !s2_valid_reg || s3_rdy;
    // The window is stage 2 and feeds stage 3, so it may only shift when stage 2 has room.
    assign s1_adv  = s1_valid_reg && s2_rdy;

    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign in_acc       = pix_in.valid && pix_in.ready;

    // ------------------------------------------------------------------
    // Stage 1: line buffer read, incoming pixel held
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] row_mem [MAX_WIDTH];
    logic [MEM_W-1:0] rd_data_reg;
    gb5_pix_t         s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    gb5_pix_t         acc_pix;

    assign acc_pix = pix_in.flush_item ? '0
                   : {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

    // Read at acceptance; the shifted column is written back as the item leaves.
    always_ff @(posedge clk)
    begin
        if (in_acc)
            rd_data_reg <= row_mem[in_column_reg];
        if (s1_adv)
            row_mem[s1_col_reg] <= {rd_data_reg[3*PIX_W-1:0], s1_pix_reg};
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg <= acc_pix;
            s1_col_reg <= in_column_reg;
            s1_ctl_reg <= acc_ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stage 2: 5x5 window; row sums are formed from it
    // ------------------------------------------------------------------
    gb5_pix_t win_reg [5][5];

    // Shift left; the new column enters on the right, oldest row on top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j++)
                    win_reg[i][j] <= '0;
        end
        else if (s1_adv)
        begin
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 4; j++)
                    win_reg[i][j] <= win_reg[i][j+1];
            win_reg[0][4] <= rd_data_reg[4*PIX_W-1:3*PIX_W];
            win_reg[1][4] <= rd_data_reg[3*PIX_W-1:2*PIX_W];
            win_reg[2][4] <= rd_data_reg[2*PIX_W-1:PIX_W];
            win_reg[3][4] <= rd_data_reg[PIX_W-1:0];
            win_reg[4][4] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            s2_ctl_reg <= s1_ctl_reg;
    end

    // Only items that release a result go on past the window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= s1_ctl_reg.emit;
        else if (s2_adv)
            s2_valid_reg <= 1'b0;
    end

    // Weighted sum along each window row, per channel.
    logic [HSUM_W-1:0] hsum [3][5];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            for (int i = 0; i < 5; i++)
                hsum[c][i] = HSUM_W'(tap_sum(
                    VSUM_W'(win_reg[i][0][c*CHAN_W +: CHAN_W]),
                    VSUM_W'(win_reg[i][1][c*CHAN_W +: CHAN_W]),
                    VSUM_W'(win_reg[i][2][c*CHAN_W +: CHAN_W]),
                    VSUM_W'(win_reg[i][3][c*CHAN_W +: CHAN_W]),
                    VSUM_W'(win_reg[i][4][c*CHAN_W +: CHAN_W])));
    end

    // ------------------------------------------------------------------
    // Stage 3: row sums registered; the column sum is formed
    // ------------------------------------------------------------------
    logic [HSUM_W-1:0] s3_hsum_reg [3][5];
    gb5_pix_t          s3_center_reg;
    logic [VSUM_W-1:0] vsum [3];

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_hsum_reg   <= hsum;
            s3_center_reg <= win_reg[2][2];
            s3_ctl_reg    <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s2_adv)
            s3_valid_reg <= 1'b1;
        else if (s3_adv)
            s3_valid_reg <= 1'b0;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            vsum[c] = tap_sum(VSUM_W'(s3_hsum_reg[c][0]), VSUM_W'(s3_hsum_reg[c][1]),
                              VSUM_W'(s3_hsum_reg[c][2]), VSUM_W'(s3_hsum_reg[c][3]),
                              VSUM_W'(s3_hsum_reg[c][4]));
    end

    // ------------------------------------------------------------------
    // Stage 4: full sums registered; divide by 100 by reciprocal multiply
    // ------------------------------------------------------------------
    logic [VSUM_W-1:0] s4_vsum_reg [3];
    gb5_pix_t          s4_center_reg;
    logic [PROD_W-1:0] prod [3];
    gb5_pix_t          result;

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s4_vsum_reg   <= vsum;
            s4_center_reg <= s3_center_reg;
            s4_ctl_reg    <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (s3_adv)
            s4_valid_reg <= 1'b1;
        else if (s4_adv)
            s4_valid_reg <= 1'b0;
    end

    // Interior pixels take the blurred value, border pixels the center copy.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod[c] = PROD_W'(s4_vsum_reg[c]) * PROD_W'(RECIP_100);
            result[c*CHAN_W +: CHAN_W] = s4_ctl_reg.interior
                                       ? prod[c][RECIP_SHIFT +: CHAN_W]
                                       : s4_center_reg[c*CHAN_W +: CHAN_W];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    gb5_pix_t out_pix_reg;
    logic     out_last_reg;

    always_ff @(posedge clk)
    begin
        if (s4_adv)
        begin
            out_pix_reg  <= result;
            out_last_reg <= s4_ctl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s4_adv)
            out_valid_reg <= 1'b1;
        else if (pix_out.ready)
            out_valid_reg <= 1'b0;
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.blue_out   = out_pix_reg[CHAN_W-1:0];
    assign pix_out.green_out  = out_pix_reg[2*CHAN_W-1:CHAN_W];
    assign pix_out.red_out    = out_pix_reg[3*CHAN_W-1:2*CHAN_W];
    assign pix_out.frame_last = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A register write restarts the frame.
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (in_column_reg == '0) && (in_row_reg == '0) &&
                   (out_column_reg == '0) && (out_row_reg == '0))
        else $error("frame positions not cleared after a register write");

    // The output column always lies inside the configured row.
    a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> ({1'b0, out_column_reg} < w_eff_reg))
        else $error("output column beyond the row width");

    // The window must not shift while a stalled stage 2 still reads it.
    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_rdy) |-> !s1_adv)
        else $error("window shifted under a stalled item");

    // The input column stays inside the configured row.
    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> ({1'b0, in_column_reg} < w_eff_reg))
        else $error("input column beyond the row width");

endmodule

`default_nettype wire
